// File: hdl/bctl_pkg.sv
package bctl_pkg;

    localparam int DEF_CACHE_SLOTS     = 16;
    localparam int DEF_MAX_BLOCK_BYTES = 4096;
    localparam int DEF_DEVICE_ID_BITS  = 8;

    localparam int DEV_W_MAX    = 16;
    localparam int BYTES_W      = 13;
    localparam int MAX_RESULTS  = 16;
    localparam int RES_CNT_W    = 5;
    localparam int SECTOR_SHIFT = 9;

    localparam logic [1:0] OP_LOOKUP     = 2'd0;
    localparam logic [1:0] OP_INSERT     = 2'd1;
    localparam logic [1:0] OP_INVALIDATE = 2'd2;
    localparam logic [1:0] OP_FLUSH      = 2'd3;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           op;
        logic [DEV_W_MAX-1:0] dev;
        logic [31:0]          blk;
        logic [15:0]          cnt;
        logic                 all_blk;
        logic                 all_dev;
        logic [31:0]          now;
        logic                 found;
        logic                 free_found;
        logic                 min_found;
        logic [31:0]          min_tick;
        logic [RES_CNT_W-1:0] n;
    } t_req;

    typedef struct packed {
        logic                 valid;
        logic [DEV_W_MAX-1:0] dev;
        logic [31:0]          blk;
        logic [BYTES_W-1:0]   bytes;
    } t_emit;

endpackage

// File: hdl/block_cache_tag_lru_top.sv
// Tag and replacement engine of a fully associative disk block cache. Each
// entry lives in a cell of a chain; an item enters a head register and then
// travels one cell per cycle while the chain is not halted, each cell
// comparing, updating and reporting on its own entry as the item passes, so
// the final result of an item is loaded into the output register after the
// item has passed every cell, and the next item can be accepted in the cycle
// after that. A flush produces one writeback per valid dirty entry of the
// device (or of every device), up to MAX_RESULTS, and marks the last one;
// when the result side stalls, the chain waits. Only one item is in the
// chain at a time, so o_in_stall is high from acceptance until the final
// result has been loaded into the output register. The slot number on each
// result lets an external store hold the block data.
module block_cache_tag_lru_top #(
    parameter int CACHE_SLOTS     = bctl_pkg::DEF_CACHE_SLOTS,
    parameter int MAX_BLOCK_BYTES = bctl_pkg::DEF_MAX_BLOCK_BYTES,
    parameter int DEVICE_ID_BITS  = bctl_pkg::DEF_DEVICE_ID_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_device_id,
    input  logic [31:0] i_block_number,
    input  logic [15:0] i_byte_count,
    input  logic        i_all_blocks,
    input  logic        i_all_devices,
    input  logic [31:0] i_now_tick,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_success,
    output logic [3:0]  o_slot,
    output logic        o_wb_valid,
    output logic [7:0]  o_wb_device,
    output logic [31:0] o_wb_block,
    output logic [12:0] o_wb_bytes,
    output logic [31:0] o_wb_offset,
    output logic        o_last,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total
);
    import bctl_pkg::*;

    localparam int SW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam logic [DEV_W_MAX-1:0] DEV_MASK =
        DEV_W_MAX'((32'd1 << DEVICE_ID_BITS) - 32'd1);

    // Chain wiring: position 0 is the head register, position k the output
    // of cell k-1.
    t_req          chain_req  [CACHE_SLOTS+1];
    logic [SW-1:0] chain_hit  [CACHE_SLOTS+1];
    logic [SW-1:0] chain_free [CACHE_SLOTS+1];
    logic [SW-1:0] chain_min  [CACHE_SLOTS+1];
    t_emit         cell_emit  [CACHE_SLOTS];
    logic [SW-1:0] cell_eslot [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] cell_wr;

    t_req  r_head;
    logic  r_busy;
    logic  en, in_acc, can_load, tail_fire, emit_fire;
    t_emit emit;
    logic [SW-1:0] emit_slot;
    t_req  tail;

    // Pending writeback: held back one step so that the last can be marked.
    logic          r_pend_valid;
    t_emit         r_pend;
    logic [SW-1:0] r_pend_slot;

    logic [31:0] r_hits, r_misses, n_hits, n_misses;

    logic        r_out_valid;
    logic        n_success, n_wb_valid, n_last, load_out;
    logic [SW-1:0] n_slot;
    t_emit       n_wb;
    logic        ins_ok;
    logic [SW-1:0] ins_slot;

    assign in_acc     = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;
    assign can_load   = !r_out_valid || !i_out_stall;
    assign tail       = chain_req[CACHE_SLOTS];

    always_comb begin
        emit      = '0;
        emit_slot = '0;
        for (int k = 0; k < CACHE_SLOTS; k++) begin
            emit      = emit | cell_emit[k];
            emit_slot = emit_slot | cell_eslot[k];
        end
    end

    // The chain halts while an emitted writeback or the final result
    // cannot be passed on.
    assign en = !(emit.valid && r_pend_valid && !can_load)
             && !(tail.valid && !can_load);
    assign emit_fire = emit.valid && en;
    assign tail_fire = tail.valid && can_load;

    assign chain_req[0]  = r_head;
    assign chain_hit[0]  = '0;
    assign chain_free[0] = '0;
    assign chain_min[0]  = '0;

    for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
        bctl_cell #(
            .SW       (SW),
            .DEV_BITS (DEVICE_ID_BITS),
            .IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (en),
            .i_req       (chain_req[g]),
            .i_hit_slot  (chain_hit[g]),
            .i_free_slot (chain_free[g]),
            .i_min_slot  (chain_min[g]),
            .o_req       (chain_req[g+1]),
            .o_hit_slot  (chain_hit[g+1]),
            .o_free_slot (chain_free[g+1]),
            .o_min_slot  (chain_min[g+1]),
            .o_emit      (cell_emit[g]),
            .o_emit_slot (cell_eslot[g]),
            .i_wr        (cell_wr[g]),
            .i_wr_req    (tail)
        );
    end

    // Final step of an item: choose the result, update counters and, for
    // an insert, write the chosen entry.
    always_comb begin
        n_hits     = r_hits;
        n_misses   = r_misses;
        n_success  = 1'b0;
        n_slot     = '0;
        n_wb_valid = 1'b0;
        n_wb       = '0;
        n_last     = 1'b1;
        load_out   = 1'b0;
        ins_ok     = 1'b0;
        ins_slot   = '0;
        cell_wr    = '0;
        if (tail_fire) begin
            load_out = 1'b1;
            case (tail.op)
                OP_LOOKUP: begin
                    if (tail.cnt != 16'd0) begin
                        if (tail.found) begin
                            n_hits    = r_hits + 32'd1;
                            n_success = 1'b1;
                            n_slot    = chain_hit[CACHE_SLOTS];
                        end else begin
                            n_misses = r_misses + 32'd1;
                        end
                    end
                end
                OP_INSERT: begin
                    if (tail.cnt != 16'd0 && tail.cnt <= 16'(MAX_BLOCK_BYTES)) begin
                        if (tail.free_found) begin
                            ins_ok   = 1'b1;
                            ins_slot = chain_free[CACHE_SLOTS];
                        end else if (tail.min_found) begin
                            ins_ok   = 1'b1;
                            ins_slot = chain_min[CACHE_SLOTS];
                        end
                    end
                    if (ins_ok) begin
                        n_success = 1'b1;
                        n_slot    = ins_slot;
                        for (int k = 0; k < CACHE_SLOTS; k++) begin
                            cell_wr[k] = ins_slot == SW'(k);
                        end
                    end
                end
                OP_INVALIDATE: begin
                    n_success = 1'b1;
                end
                default: begin
                    n_success = 1'b1;
                    if (r_pend_valid) begin
                        n_wb_valid = 1'b1;
                        n_wb       = r_pend;
                        n_slot     = r_pend_slot;
                    end
                end
            endcase
        end else if (emit_fire && r_pend_valid) begin
            load_out   = 1'b1;
            n_success  = 1'b1;
            n_wb_valid = 1'b1;
            n_wb       = r_pend;
            n_slot     = r_pend_slot;
            n_last     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_head.valid <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hits       <= '0;
            r_misses     <= '0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (tail_fire) begin
                r_busy <= 1'b0;
            end
            if (in_acc) begin
                r_head.valid <= 1'b1;
            end else if (en) begin
                r_head.valid <= 1'b0;
            end
            if (emit_fire) begin
                r_pend_valid <= 1'b1;
            end else if (tail_fire) begin
                r_pend_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_head.op         <= i_op;
            r_head.dev        <= DEV_W_MAX'(i_device_id) & DEV_MASK;
            r_head.blk        <= i_block_number;
            r_head.cnt        <= i_byte_count;
            r_head.all_blk    <= i_all_blocks;
            r_head.all_dev    <= i_all_devices;
            r_head.now        <= i_now_tick;
            r_head.found      <= 1'b0;
            r_head.free_found <= 1'b0;
            r_head.min_found  <= 1'b0;
            r_head.min_tick   <= '1;
            r_head.n          <= '0;
        end
        if (emit_fire) begin
            r_pend      <= emit;
            r_pend_slot <= emit_slot;
        end
        if (load_out) begin
            o_success    <= n_success;
            o_slot       <= 4'(n_slot);
            o_wb_valid   <= n_wb_valid;
            o_wb_device  <= n_wb.dev[7:0];
            o_wb_block   <= n_wb.blk;
            o_wb_bytes   <= n_wb.bytes;
            o_wb_offset  <= n_wb.blk << SECTOR_SHIFT;
            o_last       <= n_last;
            o_hit_total  <= n_hits;
            o_miss_total <= n_misses;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/bctl_cell.sv
module bctl_cell #(
    parameter int SW       = 4,
    parameter int DEV_BITS = 8,
    parameter int IDX      = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  bctl_pkg::t_req  i_req,
    input  logic [SW-1:0]   i_hit_slot,
    input  logic [SW-1:0]   i_free_slot,
    input  logic [SW-1:0]   i_min_slot,
    output bctl_pkg::t_req  o_req,
    output logic [SW-1:0]   o_hit_slot,
    output logic [SW-1:0]   o_free_slot,
    output logic [SW-1:0]   o_min_slot,
    output bctl_pkg::t_emit o_emit,
    output logic [SW-1:0]   o_emit_slot,
    input  logic            i_wr,
    input  bctl_pkg::t_req  i_wr_req
);
    import bctl_pkg::*;

    localparam logic [SW-1:0] MY_SLOT = SW'(IDX);

    logic                r_valid, n_valid;
    logic                r_dirty, n_dirty;
    logic [DEV_BITS-1:0] r_dev;
    logic [31:0]         r_blk;
    logic [BYTES_W-1:0]  r_bytes;
    logic [31:0]         r_tick;
    logic                tick_wr;

    t_req          r_req, n_req;
    logic [SW-1:0] r_hit_slot, n_hit_slot;
    logic [SW-1:0] r_free_slot, n_free_slot;
    logic [SW-1:0] r_min_slot, n_min_slot;

    logic act, dev_eq, blk_eq;

    // The writeback offer depends only on the passing item and the stored entry,
    // not on the enable, so the chain enable can be derived from it; entry updates wait for the enable.
    always_comb begin
        act         = i_req.valid;
        dev_eq      = r_dev == i_req.dev[DEV_BITS-1:0];
        blk_eq      = r_blk == i_req.blk;
        n_req       = i_req;
        n_hit_slot  = i_hit_slot;
        n_free_slot = i_free_slot;
        n_min_slot  = i_min_slot;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        tick_wr     = 1'b0;
        o_emit      = '0;
        o_emit_slot = '0;
        if (act) begin
            case (i_req.op)
                OP_LOOKUP: begin
                    if (i_req.cnt != 16'd0 && !i_req.found && r_valid && dev_eq && blk_eq
                        && 16'(r_bytes) >= i_req.cnt) begin
                        tick_wr     = 1'b1;
                        n_req.found = 1'b1;
                        n_hit_slot  = MY_SLOT;
                    end
                end
                OP_INSERT: begin
                    if (!r_valid && !i_req.free_found) begin
                        n_req.free_found = 1'b1;
                        n_free_slot      = MY_SLOT;
                    end
                    if (r_tick < i_req.min_tick) begin
                        n_req.min_found = 1'b1;
                        n_req.min_tick  = r_tick;
                        n_min_slot      = MY_SLOT;
                    end
                end
                OP_INVALIDATE: begin
                    if (r_valid && dev_eq && (i_req.all_blk || blk_eq)) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    if (r_valid && r_dirty && (i_req.all_dev || dev_eq)
                        && i_req.n < RES_CNT_W'(MAX_RESULTS)) begin
                        o_emit.valid = 1'b1;
                        o_emit.dev   = DEV_W_MAX'(r_dev);
                        o_emit.blk   = r_blk;
                        o_emit.bytes = r_bytes;
                        o_emit_slot  = MY_SLOT;
                        n_dirty      = 1'b0;
                        n_req.n      = i_req.n + RES_CNT_W'(1);
                    end
                end
            endcase
        end
        if (!i_en) begin
            n_valid = r_valid;
            n_dirty = r_dirty;
            tick_wr = 1'b0;
        end
        if (i_wr) begin
            n_valid = 1'b1;
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_dirty     <= 1'b0;
            r_req.valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            if (i_en) begin
                r_req <= n_req;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit_slot  <= n_hit_slot;
            r_free_slot <= n_free_slot;
            r_min_slot  <= n_min_slot;
        end
        if (i_wr) begin
            r_dev   <= i_wr_req.dev[DEV_BITS-1:0];
            r_blk   <= i_wr_req.blk;
            r_bytes <= i_wr_req.cnt[BYTES_W-1:0];
            r_tick  <= i_wr_req.now;
        end else if (tick_wr) begin
            r_tick <= i_req.now;
        end
    end

    assign o_req       = r_req;
    assign o_hit_slot  = r_hit_slot;
    assign o_free_slot = r_free_slot;
    assign o_min_slot  = r_min_slot;

endmodule
